// ----- src/msto_pkg.sv -----
// ----------------------------------------------------------------------------
// msto_pkg
// Shared types and constants for the minimum-steps-to-one core: controller
// state codes, the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package msto_pkg;

    // field widths of the request and result items
    localparam int QUERY_W = 12;
    localparam int STEP_W  = 5;

    // largest step count the result field can carry
    localparam logic [STEP_W-1:0] STEP_LIMIT = 5'd31;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_UPDATE,
        ST_FINISH
    } msto_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the query value
        logic init;      // seed entry one, set up the sweep
        logic read;      // read the half and third entries
        logic update;    // write the current entry and advance
        logic load_out;  // move the result into the output register
    } msto_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic bad;       // query is zero or above the table bound
        logic one;       // query is one, nothing to fill
        logic last;      // current entry is the queried one
        logic out_busy;  // output register holds a result not yet taken
    } msto_sts_t;

endpackage

`default_nettype wire

// ----- src/msto_ctrl.sv -----
// ----------------------------------------------------------------------------
// msto_ctrl
// Sequencer for one query: check, sweep the step table with a read and an update
// state per entry, then hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msto_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire msto_pkg::msto_sts_t sts,
    output msto_pkg::msto_cmd_t     cmd
);

    import msto_pkg::*;

    msto_state_t state_reg;
    msto_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.bad || sts.one)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.init   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = sts.last ? ST_FINISH : ST_READ;
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_busy)
        else $error("result loaded while output register busy");

    // the sweep ends on the queried entry
    a_last_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) && sts.last |=> state_reg == ST_FINISH)
        else $error("sweep did not stop at queried entry");
`endif

endmodule

`default_nettype wire

// ----- src/msto_datapath.sv -----
// ----------------------------------------------------------------------------
// msto_datapath
// Step table memory, sweep counters, three-way minimum and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msto_datapath
#(
    parameter int MAX_VALUE = 4095
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [msto_pkg::QUERY_W-1:0]  query_value,
    input  wire msto_pkg::msto_cmd_t           cmd,
    output msto_pkg::msto_sts_t                sts,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [msto_pkg::STEP_W-1:0]        step_count,
    output logic                               bad_query
);

    import msto_pkg::*;

    localparam int DEPTH = MAX_VALUE + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (AW > QUERY_W) ? AW : QUERY_W;

    logic [STEP_W-1:0]  mem [0:DEPTH-1];

    logic [QUERY_W-1:0] n_reg,     n_next;
    logic [QUERY_W-1:0] i_reg,     i_next;
    logic [QUERY_W-2:0] q3_reg,    q3_next;
    logic [1:0]         r3_reg,    r3_next;
    logic [STEP_W-1:0]  prev_reg,  prev_next;
    logic [STEP_W-1:0]  half_reg;
    logic [STEP_W-1:0]  third_reg;
    logic [STEP_W-1:0]  step_count_reg, step_count_next;
    logic               bad_query_reg,  bad_query_next;
    logic               out_valid_reg,  out_valid_next;

    logic [CW-1:0]      i_ext;
    logic [CW-1:0]      half_ext;
    logic [CW-1:0]      third_ext;
    logic [STEP_W-1:0]  best;
    logic [STEP_W-1:0]  new_steps;

    // addresses of the current entry and its predecessors
    assign i_ext     = CW'(i_reg);
    assign half_ext  = CW'(i_reg >> 1);
    assign third_ext = CW'(q3_reg);

    // smallest allowed predecessor plus one
    always_comb
    begin
        best = prev_reg;
        if (!i_reg[0] && (half_reg < best))
        begin
            best = half_reg;
        end
        if ((r3_reg == 2'd0) && (third_reg < best))
        begin
            best = third_reg;
        end
        new_steps = (best == STEP_LIMIT) ? STEP_LIMIT : best + 1'b1;
    end

    // status to the controller
    assign sts.bad      = (n_reg == '0) || (CW'(n_reg) > CW'(MAX_VALUE));
    assign sts.one      = (n_reg == QUERY_W'(1));
    assign sts.last     = (i_reg == n_reg);
    assign sts.out_busy = out_valid_reg && !out_ready;

    // sweep and output next values
    always_comb
    begin
        n_next          = n_reg;
        i_next          = i_reg;
        q3_next         = q3_reg;
        r3_next         = r3_reg;
        prev_next       = prev_reg;
        step_count_next = step_count_reg;
        bad_query_next  = bad_query_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (cmd.capture)
        begin
            n_next    = query_value;
            prev_next = '0;
        end
        if (cmd.init)
        begin
            i_next  = QUERY_W'(2);
            q3_next = '0;
            r3_next = 2'd2;
        end
        if (cmd.update)
        begin
            prev_next = new_steps;
            i_next    = i_reg + 1'b1;
            if (r3_reg == 2'd2)
            begin
                r3_next = 2'd0;
                q3_next = q3_reg + 1'b1;
            end
            else
            begin
                r3_next = r3_reg + 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            step_count_next = sts.bad ? '0 : prev_reg;
            bad_query_next  = sts.bad;
            out_valid_next  = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        i_reg          <= i_next;
        q3_reg         <= q3_next;
        r3_reg         <= r3_next;
        prev_reg       <= prev_next;
        step_count_reg <= step_count_next;
        bad_query_reg  <= bad_query_next;
    end

    // step table: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            mem[AW'(1)] <= '0;
        end
        else if (cmd.update)
        begin
            mem[i_ext[AW-1:0]] <= new_steps;
        end
        if (cmd.read)
        begin
            half_reg  <= mem[half_ext[AW-1:0]];
            third_reg <= mem[third_ext[AW-1:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign step_count = step_count_reg;
    assign bad_query  = bad_query_reg;

`ifndef SYNTHESIS
    // the sweep never runs past the queried entry
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (i_reg <= n_reg) && (i_reg >= QUERY_W'(2)))
        else $error("sweep index out of range");

    // a rejected query carries a zero count
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bad_query_reg |-> step_count_reg == '0)
        else $error("rejected query with nonzero count");

    // the divide-by-three counters track the sweep index
    a_third_track: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (CW'(q3_reg) * 3 + CW'(r3_reg)) == i_ext)
        else $error("third counter out of step with index");
`endif

endmodule

`default_nettype wire

// ----- src/min_steps_to_one_dp_core.sv -----
// ----------------------------------------------------------------------------
// min_steps_to_one_dp_core
// Fewest subtract-one / halve / third moves that bring a query value to one,
// found by a bottom-up sweep of a step table.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  request   in_valid in_ready query_value    in
//  result    out_valid out_ready step_count   out
//            bad_query
//
//  For a valid query n, each table entry from two up to n takes a read of the
//  half and third entries, then the write of the new entry, on the step
//  table memory.
//  A zero, out-of-range or unit query skips the sweep and goes from the check to the result.
//  Reset takes effect at once; the table needs no clearing pass.
//  One query is in work at a time; a waiting result holds in the output
//  register while the next query is accepted and swept.
// ----------------------------------------------------------------------------
`default_nettype none

module min_steps_to_one_dp_core
#(
    parameter int MAX_VALUE = 4095
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [msto_pkg::QUERY_W-1:0]  query_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [msto_pkg::STEP_W-1:0]        step_count,
    output logic                               bad_query
);

    import msto_pkg::*;

    msto_cmd_t cmd;
    msto_sts_t sts;

    // sequencer
    msto_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table and arithmetic
    msto_datapath #(
        .MAX_VALUE (MAX_VALUE)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_value (query_value),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .step_count  (step_count),
        .bad_query   (bad_query)
    );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for min_steps_to_one_dp_core. Queries go in over the
// request channel with random gaps. A scoreboard sweeps its own step table
// for each accepted query and checks every result in order, field by field.
// The result side stalls in random bursts; both kinds of gap stop for the final calm runs.
// ----------------------------------------------------------------------------

module tb_top;

    import msto_pkg::*;

    localparam int MAX_VALUE   = 4095;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int DRAIN_WAIT  = 32;
    localparam int RANDOM_RUNS = 100;
    localparam int CALM_RUNS   = 20;

    typedef struct packed {
        logic [STEP_W-1:0] steps;
        logic              bad;
    } step_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts step counts and checks results in order
    // ------------------------------------------------------------------------
    class min_steps_scoreboard;
        logic [7:0]   sweep_table [0:MAX_VALUE];
        step_result_t expected_q [$];
        int unsigned  errors;

        function new();
            errors = 0;
        endfunction

        // bottom-up sweep from one to the queried value
        function void note_query(logic [QUERY_W-1:0] n);
            step_result_t exp_res;
            logic [7:0]   best;
            int unsigned  i;
            if (n == 0 || int'(n) > MAX_VALUE) begin
                exp_res.steps = '0;
                exp_res.bad   = 1'b1;
            end
            else begin
                sweep_table[1] = 8'd0;
                for (i = 2; i <= n; i++) begin
                    best = sweep_table[i-1];
                    if (i % 2 == 0 && sweep_table[i/2] < best)
                        best = sweep_table[i/2];
                    if (i % 3 == 0 && sweep_table[i/3] < best)
                        best = sweep_table[i/3];
                    sweep_table[i] = best + 8'd1;
                end
                best = sweep_table[n];
                if (best > 8'(STEP_LIMIT))
                    best = 8'(STEP_LIMIT);
                exp_res.steps = best[STEP_W-1:0];
                exp_res.bad   = 1'b0;
            end
            expected_q.push_back(exp_res);
        endfunction

        // compare one result with the oldest expectation
        function void check_result(logic [STEP_W-1:0] steps, logic bad);
            step_result_t exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result step_count=%0d bad_query=%0b",
                         $time, steps, bad);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (steps !== exp_res.steps) begin
                $display("%0t: step_count mismatch expected=%0d actual=%0d",
                         $time, exp_res.steps, steps);
                errors++;
            end
            if (bad !== exp_res.bad) begin
                $display("%0t: bad_query mismatch expected=%0b actual=%0b",
                         $time, exp_res.bad, bad);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals, clock, dut
    // ------------------------------------------------------------------------
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [QUERY_W-1:0] query_value = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [STEP_W-1:0]  step_count;
    logic               bad_query;

    bit                 gaps_on     = 1'b1;
    int unsigned        cycle_cnt   = 0;

    min_steps_scoreboard sb = new();

    always #1 clk = ~clk;

    min_steps_to_one_dp_core #(
        .MAX_VALUE (MAX_VALUE)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .query_value (query_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .step_count  (step_count),
        .bad_query   (bad_query)
    );

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [QUERY_W-1:0] value);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        query_value <= value;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_query(value);
    endtask

    // mostly short sweeps, a few long ones
    function automatic logic [QUERY_W-1:0] pick_query();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 10)
            return QUERY_W'(1);
        else if (roll < 65)
            return QUERY_W'($urandom_range(2, 200));
        else if (roll < 90)
            return QUERY_W'($urandom_range(201, 1023));
        else
            return QUERY_W'($urandom());
    endfunction

    task automatic wait_results_done();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: bursty stalls, check on every accepted result
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (out_valid && out_ready)
                sb.check_result(step_count, bad_query);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // timeout guard
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [QUERY_W-1:0] directed [$];
        int unsigned        k;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, single bits, zero and one, multiples of six
        directed = '{
            12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd6, 12'd7, 12'd10,
            12'd12, 12'd18, 12'd0, 12'd1, 12'd96, 12'd127, 12'd4095,
            12'd2048, 12'd1365, 12'd2730, 12'd0, 12'd5
        };
        foreach (directed[i])
            send_request(directed[i]);
        in_valid <= 1'b0;

        // hold off until the block has drained
        wait_results_done();

        for (k = 0; k < RANDOM_RUNS; k++) begin
            if (k == RANDOM_RUNS - CALM_RUNS)
                gaps_on = 1'b0;
            send_request(pick_query());
        end
        in_valid <= 1'b0;

        wait_results_done();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
